@@ rtl/core/alr_pkg.sv @@
// Package for the aspect-locked rectangle resize block: item types,
// register indexes, handle codes and fixed widths. No dependencies.
`default_nettype none
package alr_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DimBits   = 15;
  localparam int unsigned ScaleBits = 24;
  localparam int unsigned RatioBits = 32;
  localparam logic [DimBits-1:0] SizeLimit = 15'h7fff;

  typedef enum logic [1:0] {
    REG_BASE_W = 2'd0,
    REG_BASE_H = 2'd1,
    REG_MIN_S  = 2'd2,
    REG_MAX_S  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    H_TL = 3'd0, H_T = 3'd1, H_TR = 3'd2, H_R = 3'd3,
    H_BR = 3'd4, H_B = 3'd5, H_BL = 3'd6, H_L = 3'd7
  } handle_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] proposed_width;
    logic signed [CoordBits-1:0] proposed_height;
    logic signed [CoordBits-1:0] ref_left;
    logic signed [CoordBits-1:0] ref_top;
    logic signed [CoordBits-1:0] ref_width;
    logic signed [CoordBits-1:0] ref_height;
    logic [2:0]                  handle;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_left;
    logic signed [CoordBits-1:0] out_top;
    logic [DimBits-1:0]          out_width;
    logic [DimBits-1:0]          out_height;
    logic                        ok;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/alr_div_cell.sv @@
// One restoring-division cell: retires one quotient bit of both ratios per
// cycle and passes the item on. Uses alr_pkg.
`default_nettype none
module alr_div_cell #(
  parameter int unsigned NumBits = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire logic [NumBits-1:0]          wnum_i,
  input  wire logic [NumBits-1:0]          hnum_i,
  input  wire logic [alr_pkg::DimBits:0]   wrem_i,
  input  wire logic [alr_pkg::DimBits:0]   hrem_i,
  input  wire logic [NumBits-1:0]          wq_i,
  input  wire logic [NumBits-1:0]          hq_i,
  input  wire logic [alr_pkg::DimBits-1:0] bw_i,
  input  wire logic [alr_pkg::DimBits-1:0] bh_i,
  input  wire alr_pkg::in_item_t           item_i,
  input  wire logic                        bad_i,
  output logic                             vld_o,
  output logic [NumBits-1:0]               wnum_o,
  output logic [NumBits-1:0]               hnum_o,
  output logic [alr_pkg::DimBits:0]        wrem_o,
  output logic [alr_pkg::DimBits:0]        hrem_o,
  output logic [NumBits-1:0]               wq_o,
  output logic [NumBits-1:0]               hq_o,
  output alr_pkg::in_item_t                item_o,
  output logic                             bad_o
);
  logic [alr_pkg::DimBits+1:0] wt, ht, wdiff, hdiff;
  logic [alr_pkg::DimBits:0]   wrem_d, hrem_d;
  logic                        wb, hb;

  // shift in next numerator bit, subtract divisor if it fits
  always_comb begin
    wt = {wrem_i, wnum_i[NumBits-1]};
    ht = {hrem_i, hnum_i[NumBits-1]};
    wb = wt >= {2'b00, bw_i};
    hb = ht >= {2'b00, bh_i};
    wdiff = wt - {2'b00, bw_i};
    hdiff = ht - {2'b00, bh_i};
    wrem_d = wb ? wdiff[alr_pkg::DimBits:0] : wt[alr_pkg::DimBits:0];
    hrem_d = hb ? hdiff[alr_pkg::DimBits:0] : ht[alr_pkg::DimBits:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wnum_o <= {wnum_i[NumBits-2:0], 1'b0};
    hnum_o <= {hnum_i[NumBits-2:0], 1'b0};
    wrem_o <= wrem_d;
    hrem_o <= hrem_d;
    wq_o   <= {wq_i[NumBits-2:0], wb};
    hq_o   <= {hq_i[NumBits-2:0], hb};
    item_o <= item_i;
    bad_o  <= bad_i;
  end
endmodule
`default_nettype wire

@@ rtl/core/alr_tail.sv @@
// Back end: picks and clamps the scale, scales both baseline dimensions,
// pins the rectangle and saturates. Three register stages. Uses alr_pkg.
`default_nettype none
module alr_tail #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic [alr_pkg::RatioBits-1:0] wq_i,
  input  wire logic [alr_pkg::RatioBits-1:0] hq_i,
  input  wire alr_pkg::in_item_t             item_i,
  input  wire logic                          bad_i,
  input  wire logic [alr_pkg::DimBits-1:0]   bw_i,
  input  wire logic [alr_pkg::DimBits-1:0]   bh_i,
  input  wire logic [alr_pkg::ScaleBits-1:0] min_i,
  input  wire logic [alr_pkg::ScaleBits-1:0] max_i,
  output logic                               vld_o,
  output alr_pkg::out_item_t                 res_o
);
  localparam int unsigned RB = alr_pkg::RatioBits;
  localparam int unsigned PB = alr_pkg::DimBits + alr_pkg::ScaleBits + 1;
  logic [RB-1:0] sel, cl;
  logic          v1_q, v2_q, bad1_q, bad2_q;
  logic [alr_pkg::ScaleBits-1:0] s1_q;
  alr_pkg::in_item_t it1_q, it2_q;
  logic [PB-1:0] pw_q, ph_q, rw, rh;
  logic [alr_pkg::DimBits-1:0] w, h;
  logic signed [17:0] l, t;
  alr_pkg::out_item_t res_d;

  // scale selection and clamp
  always_comb begin
    if (!item_i.handle[0]) sel = (wq_i > hq_i) ? wq_i : hq_i;
    else if (item_i.handle == alr_pkg::H_R || item_i.handle == alr_pkg::H_L) sel = wq_i;
    else sel = hq_i;
    cl = sel;
    if (cl < RB'(min_i)) cl = RB'(min_i);
    if (cl > RB'(max_i)) cl = RB'(max_i);
  end

  // scaled size: round half up, clamp to [1, limit]
  always_comb begin
    rw = (pw_q + PB'(1) * (PB'(1) << (FracBits - 1))) >> FracBits;
    rh = (ph_q + (PB'(1) << (FracBits - 1))) >> FracBits;
    w = (rw == '0) ? alr_pkg::DimBits'(1) :
        (rw > PB'(alr_pkg::SizeLimit)) ? alr_pkg::SizeLimit : rw[alr_pkg::DimBits-1:0];
    h = (rh == '0) ? alr_pkg::DimBits'(1) :
        (rh > PB'(alr_pkg::SizeLimit)) ? alr_pkg::SizeLimit : rh[alr_pkg::DimBits-1:0];
  end

  // anchor opposite the handle
  always_comb begin
    l = 18'(it2_q.ref_left);
    t = 18'(it2_q.ref_top);
    if (it2_q.handle == alr_pkg::H_TL || it2_q.handle == alr_pkg::H_BL ||
        it2_q.handle == alr_pkg::H_L)
      l = 18'(it2_q.ref_left) + 18'(it2_q.ref_width) - 18'(signed'({1'b0, w}));
    if (it2_q.handle == alr_pkg::H_TL || it2_q.handle == alr_pkg::H_T ||
        it2_q.handle == alr_pkg::H_TR)
      t = 18'(it2_q.ref_top) + 18'(it2_q.ref_height) - 18'(signed'({1'b0, h}));
    res_d = '0;
    if (!bad2_q) begin
      res_d.out_left   = (l > 18'sd32767) ? 16'sh7fff : (l < -18'sd32768) ? 16'sh8000 : l[15:0];
      res_d.out_top    = (t > 18'sd32767) ? 16'sh7fff : (t < -18'sd32768) ? 16'sh8000 : t[15:0];
      res_d.out_width  = w;
      res_d.out_height = h;
      res_d.ok         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; vld_o <= 1'b0;
    end else begin
      v1_q <= vld_i; v2_q <= v1_q; vld_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= cl[alr_pkg::ScaleBits-1:0];
    it1_q  <= item_i;
    bad1_q <= bad_i;
    pw_q   <= PB'(bw_i) * PB'(s1_q);
    ph_q   <= PB'(bh_i) * PB'(s1_q);
    it2_q  <= it1_q;
    bad2_q <= bad1_q;
    res_o  <= res_d;
  end
endmodule
`default_nettype wire

@@ rtl/core/aspect_locked_resize_rect_top.sv @@
// Top level of the aspect-locked rectangle resize: configuration registers,
// a chain of divider cells and the scaling back end. Uses alr_pkg, alr_div_cell, alr_tail.
// Pipeline: RatioBits + 3 = 35 register stages between start and done_o.
// One item per cycle.
// The divider chain (one quotient bit per cell) plus three tail stages make up the pipeline.
// Reset loads the register defaults and clears all valid flags; receiver cannot stall.
`default_nettype none
module aspect_locked_resize_rect_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire alr_pkg::in_item_t  item_i,
  output logic                    done_o,
  output alr_pkg::out_item_t      result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam int unsigned RB = alr_pkg::RatioBits;
  localparam int unsigned NC = RB;
  localparam int unsigned DB = alr_pkg::DimBits;
  localparam int unsigned FB = alr_pkg::FracBits;

  logic [DB-1:0] bw_q, bh_q;
  logic [alr_pkg::ScaleBits-1:0] min_q, max_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= DB'(1); bh_q <= DB'(1);
      min_q <= 24'd6554; max_q <= 24'd2097152;
    end else if (cfg_valid_i) begin
      unique case (alr_pkg::reg_idx_e'(cfg_index_i))
        alr_pkg::REG_BASE_W: bw_q  <= cfg_data_i[DB-1:0];
        alr_pkg::REG_BASE_H: bh_q  <= cfg_data_i[DB-1:0];
        alr_pkg::REG_MIN_S:  min_q <= cfg_data_i[alr_pkg::ScaleBits-1:0];
        alr_pkg::REG_MAX_S:  max_q <= cfg_data_i[alr_pkg::ScaleBits-1:0];
        default: ;
      endcase
    end
  end

  logic bad;
  assign bad = (item_i.proposed_width <= 0) || (item_i.proposed_height <= 0) ||
               (item_i.ref_width <= 0) || (item_i.ref_height <= 0) ||
               (bw_q == '0) || (bh_q == '0) || (min_q == '0) || (max_q < min_q);

  logic              v   [NC+1];
  logic [RB-1:0]     wn  [NC+1], hn [NC+1], wq [NC+1], hq [NC+1];
  logic [DB:0]       wr  [NC+1], hr [NC+1];
  alr_pkg::in_item_t it  [NC+1];
  logic              bd  [NC+1];

  // numerator = proposed << frac; invalid items still pass through the divider, flagged by bd
  assign v[0]  = start;
  assign wn[0] = RB'({item_i.proposed_width[DB-1:0], {FB{1'b0}}});
  assign hn[0] = RB'({item_i.proposed_height[DB-1:0], {FB{1'b0}}});
  assign wr[0] = '0;
  assign hr[0] = '0;
  assign wq[0] = '0;
  assign hq[0] = '0;
  assign it[0] = item_i;
  assign bd[0] = bad;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    alr_div_cell #(.NumBits(RB)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(v[g]), .wnum_i(wn[g]), .hnum_i(hn[g]), .wrem_i(wr[g]), .hrem_i(hr[g]),
      .wq_i(wq[g]), .hq_i(hq[g]), .bw_i(bw_q), .bh_i(bh_q), .item_i(it[g]),
      .bad_i(bd[g]),
      .vld_o(v[g+1]), .wnum_o(wn[g+1]), .hnum_o(hn[g+1]), .wrem_o(wr[g+1]),
      .hrem_o(hr[g+1]), .wq_o(wq[g+1]), .hq_o(hq[g+1]), .item_o(it[g+1]),
      .bad_o(bd[g+1])
    );
  end

  alr_tail #(.FracBits(FB)) u_tail (
    .clk_i, .rst_ni, .vld_i(v[NC]), .wq_i(wq[NC]), .hq_i(hq[NC]), .item_i(it[NC]),
    .bad_i(bd[NC]), .bw_i(bw_q), .bh_i(bh_q), .min_i(min_q), .max_i(max_q),
    .vld_o(done_o), .res_o(result_o)
  );
endmodule
`default_nettype wire
